@@ hdl/pcr_pkg.sv @@
// Package for the packet classify and rewrite unit.
// Holds sizes, codes, state machine types and the controller/datapath
// command and status structs. Depends on nothing.
package pcr_pkg;

    localparam int NUM_PORTS    = 4;
    localparam int HEADER_WORDS = 11;
    localparam int COUNTER_BITS = 48;
    localparam int NUM_KINDS    = 7;
    localparam int BUF_BYTES    = HEADER_WORDS * 8;
    localparam int NUM_COUNTERS = NUM_KINDS * NUM_PORTS;

    localparam int FILL_W     = $clog2(BUF_BYTES + 1);
    localparam int BYTE_IDX_W = $clog2(BUF_BYTES);
    localparam int WORD_IDX_W = $clog2(HEADER_WORDS);
    localparam int CNT_IDX_W  = $clog2(NUM_COUNTERS);
    localparam int HW_IDX_W   = 5;
    localparam int PORT_W     = 2;
    localparam int SEL_W      = 5;
    localparam int CV_W       = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int FLAGS_W    = 9;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 120;

    // Frame offsets and protocol values.
    localparam int IP_HDR_OFF  = 14;
    localparam int IP_CSUM_OFF = 24;
    localparam int CSUM_HW     = 5;
    localparam logic [15:0] ETH_ARP   = 16'h0806;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic MODE_COUNTER = 1'b1;

    localparam logic [1:0] RK_DATA    = 2'd0;
    localparam logic [1:0] RK_VERDICT = 2'd1;
    localparam logic [1:0] RK_COUNTER = 2'd2;

    localparam logic [1:0] V_FORWARD = 2'd0;
    localparam logic [1:0] V_SHORT   = 2'd1;
    localparam logic [1:0] V_NONUDP  = 2'd2;

    localparam int K_ARP         = 0;
    localparam int K_IPV4        = 1;
    localparam int K_UDP         = 2;
    localparam int K_NONUDP      = 3;
    localparam int K_REWRITE     = 4;
    localparam int K_SHORT       = 5;
    localparam int K_NONUDP_DROP = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_MAC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_IP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_IP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT = 3'd6;

    localparam int F_UDP_ONLY = 0;
    localparam int F_SWAP     = 1;
    localparam int F_REWRITE  = 2;
    localparam int F_SRC_MAC  = 3;
    localparam int F_DST_MAC  = 4;
    localparam int F_SRC_IP   = 5;
    localparam int F_DST_IP   = 6;
    localparam int F_SRC_PORT = 7;
    localparam int F_DST_PORT = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CSUM,
        ST_CSUM_WR,
        ST_VERDICT,
        ST_WORDS,
        ST_OVF
    } state_t;

    typedef enum logic [1:0] {
        PH_AWAIT,
        PH_PASS,
        PH_DROP
    } phase_t;

    typedef enum logic [2:0] {
        OSEL_COUNTER,
        OSEL_PASS,
        OSEL_VERDICT,
        OSEL_BUF,
        OSEL_OVF
    } out_sel_t;

    typedef struct packed {
        logic                  ins;
        logic                  decide;
        logic                  csum_step;
        logic                  csum_write;
        logic                  fill_clr;
        logic                  out_load;
        out_sel_t              out_sel;
        logic                  out_last;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [HW_IDX_W-1:0]   hw_idx;
    } cmd_t;

    typedef struct packed {
        logic                  need_decide;
        logic                  cip;
        logic                  fwd;
        logic [HW_IDX_W-1:0]   hw_last;
        logic [WORD_IDX_W-1:0] word_last;
        logic                  has_ovf;
        logic                  out_free;
    } status_t;

endpackage

@@ hdl/pcr_ctrl.sv @@
// Controller state machine of the packet classify and rewrite unit.
// Sequences header buffering, decision, checksum and result emission.
// Depends on pcr_pkg.
module pcr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_mode,
    input  logic              s_tlast,
    input  pcr_pkg::status_t  status,
    output pcr_pkg::cmd_t     cmd
);

    pcr_pkg::state_t state_reg, state_next;
    pcr_pkg::phase_t phase_reg, phase_next;
    logic last_hold_reg, last_hold_next;
    logic [pcr_pkg::WORD_IDX_W-1:0] word_idx_reg, word_idx_next;
    logic [pcr_pkg::HW_IDX_W-1:0] hw_idx_reg, hw_idx_next;
    logic accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pcr_pkg::ST_IDLE;
            phase_reg     <= pcr_pkg::PH_AWAIT;
            last_hold_reg <= 1'b0;
            word_idx_reg  <= '0;
            hw_idx_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_hold_reg <= last_hold_next;
            word_idx_reg  <= word_idx_next;
            hw_idx_reg    <= hw_idx_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        last_hold_next = last_hold_reg;
        word_idx_next  = word_idx_reg;
        hw_idx_next    = hw_idx_reg;
        unique case (state_reg)
            pcr_pkg::ST_IDLE: begin
                if (accept && s_mode != pcr_pkg::MODE_COUNTER) begin
                    unique case (phase_reg)
                        pcr_pkg::PH_PASS, pcr_pkg::PH_DROP: begin
                            if (s_tlast) begin
                                phase_next = pcr_pkg::PH_AWAIT;
                            end
                        end
                        default: begin
                            if (status.need_decide) begin
                                state_next     = pcr_pkg::ST_DECIDE;
                                last_hold_next = s_tlast;
                            end
                        end
                    endcase
                end
            end
            pcr_pkg::ST_DECIDE: begin
                hw_idx_next = '0;
                state_next  = status.cip ? pcr_pkg::ST_CSUM : pcr_pkg::ST_VERDICT;
            end
            pcr_pkg::ST_CSUM: begin
                if (hw_idx_reg == status.hw_last) begin
                    state_next = pcr_pkg::ST_CSUM_WR;
                end else begin
                    hw_idx_next = hw_idx_reg + 1'b1;
                end
            end
            pcr_pkg::ST_CSUM_WR: begin
                state_next = pcr_pkg::ST_VERDICT;
            end
            pcr_pkg::ST_VERDICT: begin
                if (status.out_free) begin
                    if (status.fwd) begin
                        word_idx_next = '0;
                        state_next    = pcr_pkg::ST_WORDS;
                    end else begin
                        phase_next = last_hold_reg ? pcr_pkg::PH_AWAIT : pcr_pkg::PH_DROP;
                        state_next = pcr_pkg::ST_IDLE;
                    end
                end
            end
            pcr_pkg::ST_WORDS: begin
                if (status.out_free) begin
                    if (word_idx_reg == status.word_last) begin
                        if (status.has_ovf) begin
                            state_next = pcr_pkg::ST_OVF;
                        end else begin
                            phase_next = last_hold_reg ? pcr_pkg::PH_AWAIT
                                                       : pcr_pkg::PH_PASS;
                            state_next = pcr_pkg::ST_IDLE;
                        end
                    end else begin
                        word_idx_next = word_idx_reg + 1'b1;
                    end
                end
            end
            pcr_pkg::ST_OVF: begin
                if (status.out_free) begin
                    phase_next = last_hold_reg ? pcr_pkg::PH_AWAIT : pcr_pkg::PH_PASS;
                    state_next = pcr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pcr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.out_sel  = pcr_pkg::OSEL_COUNTER;
        cmd.word_idx = word_idx_reg;
        cmd.hw_idx   = hw_idx_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            pcr_pkg::ST_IDLE: begin
                s_tready = status.out_free;
                if (accept) begin
                    if (s_mode == pcr_pkg::MODE_COUNTER) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = pcr_pkg::OSEL_COUNTER;
                        cmd.out_last = 1'b1;
                    end else begin
                        unique case (phase_reg)
                            pcr_pkg::PH_PASS: begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = pcr_pkg::OSEL_PASS;
                                cmd.out_last = 1'b1;
                            end
                            pcr_pkg::PH_AWAIT: begin
                                cmd.ins = 1'b1;
                            end
                            default: begin
                                cmd.ins = 1'b0;
                            end
                        endcase
                    end
                end
            end
            pcr_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
            end
            pcr_pkg::ST_CSUM: begin
                cmd.csum_step = 1'b1;
            end
            pcr_pkg::ST_CSUM_WR: begin
                cmd.csum_write = 1'b1;
            end
            pcr_pkg::ST_VERDICT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = pcr_pkg::OSEL_VERDICT;
                    cmd.out_last = !status.fwd;
                    cmd.fill_clr = !status.fwd;
                end
            end
            pcr_pkg::ST_WORDS: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = pcr_pkg::OSEL_BUF;
                    cmd.out_last = (word_idx_reg == status.word_last) && !status.has_ovf;
                    cmd.fill_clr = (word_idx_reg == status.word_last) && !status.has_ovf;
                end
            end
            pcr_pkg::ST_OVF: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = pcr_pkg::OSEL_OVF;
                    cmd.out_last = 1'b1;
                    cmd.fill_clr = 1'b1;
                end
            end
            default: begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/pcr_datapath.sv @@
// Datapath of the packet classify and rewrite unit: configuration registers,
// header buffer, classifier, checksum unit, event counters and the
// result register. Depends on pcr_pkg.
module pcr_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  pcr_pkg::cmd_t                   cmd,
    output pcr_pkg::status_t                status,
    input  logic [pcr_pkg::PORT_W-1:0]      src_port_id,
    input  logic [63:0]                     data_word,
    input  logic [3:0]                      byte_count,
    input  logic                            last_word,
    input  logic [pcr_pkg::SEL_W-1:0]       counter_select,
    input  logic                            cfg_valid,
    input  logic [pcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      result_kind,
    output logic [63:0]                     out_word,
    output logic [3:0]                      out_bytes,
    output logic                            out_last,
    output logic [1:0]                      verdict,
    output logic [pcr_pkg::CV_W-1:0]        counter_value
);

    logic [pcr_pkg::FLAGS_W-1:0] flags_reg;
    logic [47:0] src_mac_reg, dst_mac_reg;
    logic [31:0] src_ip_reg, dst_ip_reg;
    logic [15:0] src_udp_reg, dst_udp_reg;

    // The header is held as whole words; hdr_b and hdr_next are byte views.
    logic [63:0] hdr_reg [pcr_pkg::HEADER_WORDS];
    logic [7:0] hdr_b [pcr_pkg::BUF_BYTES];
    logic [7:0] hdr_next [pcr_pkg::BUF_BYTES];
    logic [pcr_pkg::FILL_W-1:0] fill_reg, fill_next, fill_ins;
    logic [63:0] ovf_reg, ovf_next;
    logic [3:0] ovn_reg, ovn_next;
    logic [pcr_pkg::PORT_W-1:0] port_reg;
    logic [1:0] verdict_reg;
    logic [pcr_pkg::HW_IDX_W-1:0] hw_last_reg;
    logic [16:0] acc_reg, acc_next;
    logic [pcr_pkg::COUNTER_BITS-1:0] cnt_reg [pcr_pkg::NUM_COUNTERS];

    logic m_valid_reg;
    logic [1:0] kind_reg, verdict_out_reg;
    logic [63:0] word_reg;
    logic [3:0] bytes_reg;
    logic last_reg;
    logic [pcr_pkg::CV_W-1:0] cv_reg;

    logic [3:0] n_in;
    logic [63:0] data_m;
    logic [pcr_pkg::FILL_W-1:0] room;

    // Classifier results.
    logic [1:0] dec_verdict;
    logic [pcr_pkg::NUM_KINDS-1:0] dec_mask;
    logic dec_swap, dec_rw, dec_cip, dec_cudp, do_swap;
    logic [5:0] ihl;
    logic [pcr_pkg::FILL_W-1:0] len_ip, len_udp;
    logic [15:0] et;

    logic [15:0] csum_word;
    logic [17:0] csum_sum;
    logic [15:0] csum_val;

    logic [pcr_pkg::FILL_W-1:0] word_base, word_rem;
    logic [3:0] word_nb;
    logic [63:0] buf_word;
    logic [pcr_pkg::COUNTER_BITS-1:0] cnt_rd;

    always_comb begin
        for (int j = 0; j < pcr_pkg::BUF_BYTES; j++) begin
            hdr_b[j] = hdr_reg[j / 8][63 - 8 * (j % 8) -: 8];
        end
    end

    // Input word trimming and overflow split.
    always_comb begin
        n_in = (byte_count > 4'd8) ? 4'd8 : byte_count;
        for (int k = 0; k < 8; k++) begin
            data_m[63-8*k -: 8] = (4'(k) < n_in) ? data_word[63-8*k -: 8] : 8'h00;
        end
        room     = pcr_pkg::FILL_W'(pcr_pkg::BUF_BYTES) - fill_reg;
        fill_ins = fill_reg + pcr_pkg::FILL_W'(n_in);
        if (fill_ins > pcr_pkg::FILL_W'(pcr_pkg::BUF_BYTES)) begin
            fill_ins = pcr_pkg::FILL_W'(pcr_pkg::BUF_BYTES);
        end
        if (pcr_pkg::FILL_W'(n_in) > room) begin
            ovn_next = n_in - room[3:0];
            ovf_next = data_m << {room[2:0], 3'b000};
        end else begin
            ovn_next = 4'd0;
            ovf_next = 64'd0;
        end
    end

    // Classification of the buffered frame.
    always_comb begin
        et          = {hdr_b[12], hdr_b[13]};
        ihl         = {hdr_b[pcr_pkg::IP_HDR_OFF][3:0], 2'b00};
        len_ip      = pcr_pkg::FILL_W'(pcr_pkg::IP_HDR_OFF) + pcr_pkg::FILL_W'(ihl);
        len_udp     = len_ip + pcr_pkg::FILL_W'(8);
        dec_verdict = pcr_pkg::V_FORWARD;
        dec_mask    = '0;
        dec_swap    = 1'b0;
        dec_rw      = 1'b0;
        if (fill_reg < pcr_pkg::FILL_W'(14)) begin
            dec_mask[pcr_pkg::K_SHORT] = 1'b1;
            dec_verdict = pcr_pkg::V_SHORT;
        end else if (et == pcr_pkg::ETH_ARP) begin
            dec_mask[pcr_pkg::K_ARP] = 1'b1;
            dec_swap = 1'b1;
        end else if (et != pcr_pkg::ETH_IPV4) begin
            dec_mask[pcr_pkg::K_NONUDP] = 1'b1;
            if (flags_reg[pcr_pkg::F_UDP_ONLY]) begin
                dec_mask[pcr_pkg::K_NONUDP_DROP] = 1'b1;
                dec_verdict = pcr_pkg::V_NONUDP;
            end else begin
                dec_swap = 1'b1;
            end
        end else if (fill_reg < pcr_pkg::FILL_W'(34) || ihl < 6'd20 || fill_reg < len_ip) begin
            dec_mask[pcr_pkg::K_SHORT] = 1'b1;
            dec_verdict = pcr_pkg::V_SHORT;
        end else begin
            dec_mask[pcr_pkg::K_IPV4] = 1'b1;
            if (hdr_b[23] != pcr_pkg::PROTO_UDP) begin
                dec_mask[pcr_pkg::K_NONUDP] = 1'b1;
                if (flags_reg[pcr_pkg::F_UDP_ONLY]) begin
                    dec_mask[pcr_pkg::K_NONUDP_DROP] = 1'b1;
                    dec_verdict = pcr_pkg::V_NONUDP;
                end else begin
                    dec_swap = 1'b1;
                end
            end else begin
                dec_mask[pcr_pkg::K_UDP] = 1'b1;
                if (!flags_reg[pcr_pkg::F_REWRITE]) begin
                    dec_swap = 1'b1;
                end else if (fill_reg < len_udp) begin
                    dec_mask[pcr_pkg::K_SHORT] = 1'b1;
                    dec_verdict = pcr_pkg::V_SHORT;
                end else begin
                    dec_mask[pcr_pkg::K_REWRITE] = 1'b1;
                    dec_rw = 1'b1;
                end
            end
        end
        dec_cip  = dec_rw && (flags_reg[pcr_pkg::F_SRC_IP] || flags_reg[pcr_pkg::F_DST_IP]);
        dec_cudp = flags_reg[pcr_pkg::F_SRC_PORT] || flags_reg[pcr_pkg::F_DST_PORT];
        do_swap  = flags_reg[pcr_pkg::F_SWAP] && (dec_swap || (dec_rw &&
                   !(flags_reg[pcr_pkg::F_SRC_MAC] || flags_reg[pcr_pkg::F_DST_MAC])));
    end

    // One 16-bit header word per step; the checksum field itself counts as zero.
    always_comb begin
        if (cmd.hw_idx == pcr_pkg::HW_IDX_W'(pcr_pkg::CSUM_HW)) begin
            csum_word = 16'h0000;
        end else begin
            csum_word = {hdr_b[pcr_pkg::BYTE_IDX_W'(pcr_pkg::IP_HDR_OFF)
                               + pcr_pkg::BYTE_IDX_W'({cmd.hw_idx, 1'b0})],
                         hdr_b[pcr_pkg::BYTE_IDX_W'(pcr_pkg::IP_HDR_OFF + 1)
                               + pcr_pkg::BYTE_IDX_W'({cmd.hw_idx, 1'b0})]};
        end
        csum_sum = {1'b0, acc_reg} + {2'b00, csum_word};
        acc_next = acc_reg;
        if (cmd.decide) begin
            acc_next = '0;
        end else if (cmd.csum_step) begin
            acc_next = {1'b0, csum_sum[15:0]} + {15'd0, csum_sum[17:16]};
        end
        csum_val = ~acc_reg[15:0];
    end

    // Header buffer update: byte insertion, rewrite or swap, checksum write.
    always_comb begin
        logic [pcr_pkg::FILL_W:0] pos;
        logic [pcr_pkg::FILL_W-1:0] ju;
        pos = '0;
        ju  = '0;
        for (int j = 0; j < pcr_pkg::BUF_BYTES; j++) begin
            hdr_next[j] = hdr_b[j];
        end
        if (cmd.ins) begin
            for (int k = 0; k < 8; k++) begin
                pos = {1'b0, fill_reg} + (pcr_pkg::FILL_W + 1)'(k);
                if (4'(k) < n_in && pos < (pcr_pkg::FILL_W + 1)'(pcr_pkg::BUF_BYTES)) begin
                    hdr_next[pos[pcr_pkg::BYTE_IDX_W-1:0]] = data_m[63-8*k -: 8];
                end
            end
        end
        if (cmd.decide) begin
            if (do_swap) begin
                for (int j = 0; j < 6; j++) begin
                    hdr_next[j]     = hdr_b[j+6];
                    hdr_next[j+6]   = hdr_b[j];
                end
            end
            if (dec_rw) begin
                for (int j = 0; j < 6; j++) begin
                    if (flags_reg[pcr_pkg::F_DST_MAC]) begin
                        hdr_next[j] = dst_mac_reg[47-8*j -: 8];
                    end
                    if (flags_reg[pcr_pkg::F_SRC_MAC]) begin
                        hdr_next[j+6] = src_mac_reg[47-8*j -: 8];
                    end
                end
                for (int j = 0; j < 4; j++) begin
                    if (flags_reg[pcr_pkg::F_SRC_IP]) begin
                        hdr_next[26+j] = src_ip_reg[31-8*j -: 8];
                    end
                    if (flags_reg[pcr_pkg::F_DST_IP]) begin
                        hdr_next[30+j] = dst_ip_reg[31-8*j -: 8];
                    end
                end
                for (int j = 0; j < pcr_pkg::BUF_BYTES; j++) begin
                    ju = pcr_pkg::FILL_W'(j);
                    if (flags_reg[pcr_pkg::F_SRC_PORT] && ju == len_ip) begin
                        hdr_next[j] = src_udp_reg[15:8];
                    end
                    if (flags_reg[pcr_pkg::F_SRC_PORT] && ju == len_ip + 1'b1) begin
                        hdr_next[j] = src_udp_reg[7:0];
                    end
                    if (flags_reg[pcr_pkg::F_DST_PORT] && ju == len_ip + 2'd2) begin
                        hdr_next[j] = dst_udp_reg[15:8];
                    end
                    if (flags_reg[pcr_pkg::F_DST_PORT] && ju == len_ip + 2'd3) begin
                        hdr_next[j] = dst_udp_reg[7:0];
                    end
                    if ((dec_cip || dec_cudp) &&
                        (ju == len_ip + 3'd6 || ju == len_ip + 3'd7)) begin
                        hdr_next[j] = 8'h00;
                    end
                end
            end
        end
        if (cmd.csum_write) begin
            hdr_next[pcr_pkg::IP_CSUM_OFF]     = csum_val[15:8];
            hdr_next[pcr_pkg::IP_CSUM_OFF + 1] = csum_val[7:0];
        end
    end

    // Buffered word read for emission, and counter read select.
    always_comb begin
        word_base = pcr_pkg::FILL_W'({cmd.word_idx, 3'b000});
        word_rem  = fill_reg - word_base;
        word_nb   = (word_rem >= pcr_pkg::FILL_W'(8)) ? 4'd8 : word_rem[3:0];
        for (int k = 0; k < 8; k++) begin
            buf_word[63-8*k -: 8] = (4'(k) < word_nb)
                ? hdr_b[pcr_pkg::BYTE_IDX_W'({cmd.word_idx, 3'(k)})] : 8'h00;
        end
        if (counter_select < pcr_pkg::SEL_W'(pcr_pkg::NUM_COUNTERS)) begin
            cnt_rd = cnt_reg[counter_select[pcr_pkg::CNT_IDX_W-1:0]];
        end else begin
            cnt_rd = '0;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.ins) begin
            fill_next = fill_ins;
        end else if (cmd.fill_clr) begin
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg   <= pcr_pkg::FLAGS_W'(2);
            src_mac_reg <= '0;
            dst_mac_reg <= '0;
            src_ip_reg  <= '0;
            dst_ip_reg  <= '0;
            src_udp_reg <= 16'd1;
            dst_udp_reg <= 16'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pcr_pkg::CFG_FLAGS:    flags_reg   <= cfg_data[pcr_pkg::FLAGS_W-1:0];
                pcr_pkg::CFG_SRC_MAC:  src_mac_reg <= cfg_data[47:0];
                pcr_pkg::CFG_DST_MAC:  dst_mac_reg <= cfg_data[47:0];
                pcr_pkg::CFG_SRC_IP:   src_ip_reg  <= cfg_data[31:0];
                pcr_pkg::CFG_DST_IP:   dst_ip_reg  <= cfg_data[31:0];
                pcr_pkg::CFG_SRC_PORT: src_udp_reg <= cfg_data[15:0];
                pcr_pkg::CFG_DST_PORT: dst_udp_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < pcr_pkg::BUF_BYTES; j++) begin
            hdr_reg[j / 8][63 - 8 * (j % 8) -: 8] <= hdr_next[j];
        end
        if (cmd.ins) begin
            ovf_reg  <= ovf_next;
            port_reg <= src_port_id;
        end
        if (cmd.decide) begin
            verdict_reg <= dec_verdict;
            hw_last_reg <= pcr_pkg::HW_IDX_W'(ihl >> 1) - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ovn_reg  <= '0;
            acc_reg  <= '0;
            for (int i = 0; i < pcr_pkg::NUM_COUNTERS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            fill_reg <= fill_next;
            acc_reg  <= acc_next;
            if (cmd.ins) begin
                ovn_reg <= ovn_next;
            end
            for (int p = 0; p < pcr_pkg::NUM_PORTS; p++) begin
                for (int k = 0; k < pcr_pkg::NUM_KINDS; k++) begin
                    if (cmd.decide && port_reg == pcr_pkg::PORT_W'(p) && dec_mask[k]) begin
                        cnt_reg[p*pcr_pkg::NUM_KINDS+k] <= cnt_reg[p*pcr_pkg::NUM_KINDS+k] + 1'b1;
                    end
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            last_reg        <= cmd.out_last;
            kind_reg        <= pcr_pkg::RK_DATA;
            word_reg        <= '0;
            bytes_reg       <= '0;
            verdict_out_reg <= pcr_pkg::V_FORWARD;
            cv_reg          <= '0;
            case (cmd.out_sel)
                pcr_pkg::OSEL_COUNTER: begin
                    kind_reg <= pcr_pkg::RK_COUNTER;
                    cv_reg   <= pcr_pkg::CV_W'(cnt_rd);
                end
                pcr_pkg::OSEL_PASS: begin
                    word_reg  <= data_m;
                    bytes_reg <= n_in;
                end
                pcr_pkg::OSEL_VERDICT: begin
                    kind_reg        <= pcr_pkg::RK_VERDICT;
                    verdict_out_reg <= verdict_reg;
                end
                pcr_pkg::OSEL_BUF: begin
                    word_reg  <= buf_word;
                    bytes_reg <= word_nb;
                end
                pcr_pkg::OSEL_OVF: begin
                    word_reg  <= ovf_reg;
                    bytes_reg <= ovn_reg;
                end
                default: begin
                end
            endcase
        end
    end

    assign status.need_decide = last_word || (fill_ins == pcr_pkg::FILL_W'(pcr_pkg::BUF_BYTES));
    assign status.cip         = dec_cip;
    assign status.fwd         = (verdict_reg == pcr_pkg::V_FORWARD);
    assign status.hw_last     = hw_last_reg;
    assign status.word_last   = pcr_pkg::WORD_IDX_W'((fill_reg - 1'b1) >> 3);
    assign status.has_ovf     = (ovn_reg != 4'd0);
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign result_kind   = kind_reg;
    assign out_word      = word_reg;
    assign out_bytes     = bytes_reg;
    assign out_last      = last_reg;
    assign verdict       = verdict_out_reg;
    assign counter_value = cv_reg;

endmodule

@@ hdl/packet_classify_rewrite_unit.sv @@
// Top level of the packet classify and rewrite unit.
// Joins pcr_ctrl and pcr_datapath and packs the stream ports.
// Depends on pcr_pkg, pcr_ctrl and pcr_datapath.
//
// Packet words are buffered until 88 header bytes are held or the packet
// ends, then the frame is classified as ARP, IPv4 UDP, IPv4 other, non-IPv4
// or short, and dropped or forwarded with MACs swapped or fields replaced.
// The decision is a single state; an IPv4 checksum recomputation then takes
// one 16-bit word per cycle through one adder, and the verdict plus each
// buffered word of a forwarded frame leave at one result per cycle unless
// m_tready stalls them. Words past the decision and counter reads go to
// the result register. Per-port event counters wrap and are cleared by reset.
module packet_classify_rewrite_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // src_port_id[1:0], data_word[65:2], byte_count[69:66], counter_select[74:70]
    input  logic [pcr_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[0]
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_word[63:0], out_bytes[67:64], verdict[69:68], counter_value[117:70]
    output logic [pcr_pkg::M_TDATA_W-1:0]   m_tdata,
    // result_kind[1:0]
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pcr_pkg::cmd_t    cmd;
    pcr_pkg::status_t status;
    logic [63:0] out_word;
    logic [3:0] out_bytes;
    logic [1:0] verdict;
    logic [pcr_pkg::CV_W-1:0] counter_value;

    assign cfg_ready = 1'b1;

    pcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser[0]),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    pcr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .src_port_id    (s_tdata[1:0]),
        .data_word      (s_tdata[65:2]),
        .byte_count     (s_tdata[69:66]),
        .last_word      (s_tlast),
        .counter_select (s_tdata[74:70]),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .result_kind    (m_tuser),
        .out_word       (out_word),
        .out_bytes      (out_bytes),
        .out_last       (m_tlast),
        .verdict        (verdict),
        .counter_value  (counter_value)
    );

    assign m_tdata = {2'b00, counter_value, verdict, out_bytes, out_word};

endmodule
